### hdl/nnfd_pkg.sv
package nnfd_pkg;

  // Fixed limits of this block
  localparam int MaxSourceSide = 4096;
  localparam int MaxOutputSide = 240;

  // Field and register widths
  localparam int PixW       = 16;
  localparam int CfgSideW   = 13;
  localparam int CfgTargetW = 16;
  localparam int CfgDataW   = 16;
  localparam int CfgIdxW    = 2;
  localparam int SrcSideW   = $clog2(MaxSourceSide + 1);
  localparam int SrcIdxW    = $clog2(MaxSourceSide);
  localparam int OutSideW   = $clog2(MaxOutputSide + 1);

  // Shared divider operands: product of a source side and an output side
  localparam int DivNumW = SrcSideW + OutSideW;
  localparam int DivDenW = SrcSideW;
  localparam int DivCntW = $clog2(DivNumW);

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgSourceWidth  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgSourceHeight = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CfgTargetSide   = CfgIdxW'(2);

  // Register reset values
  localparam logic [CfgSideW-1:0]   RstSourceWidth  = CfgSideW'(320);
  localparam logic [CfgSideW-1:0]   RstSourceHeight = CfgSideW'(320);
  localparam logic [CfgTargetW-1:0] RstTargetSide   = CfgTargetW'(240);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_BGO,
    S_BWAIT,
    S_EVAL,
    S_NGO,
    S_NWAIT
  } nnfd_state_e;

  typedef enum logic [1:0] {
    DEST_DIM,
    DEST_COL,
    DEST_ROW
  } nnfd_dest_e;

  // controller -> datapath
  typedef struct packed {
    logic load_in;
    logic begin_img;
    logic mul_begin;
    logic mul_step;
    logic div_start;
    logic div_write;
    logic emit;
    logic advance;
  } nnfd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic begin_req;
    logic begin_div;
    logic hit;
    logic stat_hit;
    logic need_div;
    logic out_free;
    logic div_busy;
    logic div_done;
  } nnfd_stat_t;

endpackage

### hdl/nnfd_div.sv
module nnfd_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [nnfd_pkg::DivNumW-1:0]  num_i,
  input  logic [nnfd_pkg::DivDenW-1:0]  den_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic [nnfd_pkg::DivNumW-1:0]  quo_o
);
  import nnfd_pkg::*;

  logic [DivDenW-1:0] rem_q, rem_d;
  logic [DivNumW-1:0] quo_q, quo_d;
  logic [DivDenW-1:0] den_q;
  logic [DivCntW-1:0] cnt_q;
  logic               busy_q, done_q;
  logic [DivDenW:0]   rem_sh;
  logic [DivDenW+1:0] diff;

  // restoring radix-2, one quotient bit per cycle
  always_comb begin
    rem_sh = {rem_q, quo_q[DivNumW-1]};
    diff   = {1'b0, rem_sh} - {2'b00, den_q};
    if (!diff[DivDenW+1]) begin
      rem_d = diff[DivDenW-1:0];
      quo_d = {quo_q[DivNumW-2:0], 1'b1};
    end else begin
      rem_d = rem_sh[DivDenW-1:0];
      quo_d = {quo_q[DivNumW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + DivCntW'(1);
      if (cnt_q == DivCntW'(DivNumW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

`ifndef SYNTHESIS
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still busy");
`endif

endmodule

### hdl/nnfd_dp.sv
module nnfd_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [nnfd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [nnfd_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic [nnfd_pkg::PixW-1:0]      pixel_in_i,
  input  logic                           start_of_image_i,
  input  nnfd_pkg::nnfd_cmd_t            cmd_i,
  output nnfd_pkg::nnfd_stat_t           stat_o,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [nnfd_pkg::PixW-1:0]      pixel_out_o,
  output logic [nnfd_pkg::OutSideW-1:0]  out_x_o,
  output logic [nnfd_pkg::OutSideW-1:0]  out_y_o,
  output logic [nnfd_pkg::OutSideW-1:0]  out_width_o,
  output logic [nnfd_pkg::OutSideW-1:0]  out_height_o,
  output logic                           last_pixel_o,
  output logic                           status_o
);
  import nnfd_pkg::*;

  // configuration
  logic [CfgSideW-1:0]   src_w_q, src_h_q;
  logic [CfgTargetW-1:0] tgt_q;

  // latched input beat
  logic [PixW-1:0] pix_q;
  logic            sof_q;

  // position state
  logic [SrcIdxW-1:0]  src_col_q, src_col_d, src_row_q, src_row_d;
  logic [OutSideW-1:0] out_col_q, out_col_d, out_row_q, out_row_d;
  logic [SrcIdxW-1:0]  nwc_q, nwc_d, nwr_q, nwr_d;
  logic [OutSideW-1:0] cw_q, cw_d, ch_q, ch_d;
  logic                long_w_q, long_w_d;

  // multiply / divide staging
  logic [DivNumW-1:0]  prod_q;
  logic [DivDenW-1:0]  den_q;
  nnfd_dest_e          dest_q;
  logic [SrcSideW-1:0] mul_a;
  logic [OutSideW-1:0] mul_b;
  logic [DivDenW-1:0]  mul_den;
  nnfd_dest_e          mul_dest;
  logic                div_busy, div_done;
  logic [DivNumW-1:0]  div_quo;
  logic [OutSideW-1:0] quo_dim;

  // output register
  logic                out_valid_q;
  logic [PixW-1:0]     out_pix_q;
  logic [OutSideW-1:0] out_x_q, out_y_q, out_w_q, out_h_q;
  logic                out_last_q, out_status_q;

  // derived
  logic [SrcSideW-1:0] eff_w, eff_h;
  logic [OutSideW-1:0] side;
  logic                fits, w_long;
  logic [SrcSideW:0]   col_p1, row_p1;
  logic [OutSideW-1:0] out_col_p1, out_row_p1;
  logic                row_case, src_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= RstSourceWidth;
      src_h_q <= RstSourceHeight;
      tgt_q   <= RstTargetSide;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgSourceWidth:  src_w_q <= cfg_data_i[CfgSideW-1:0];
        CfgSourceHeight: src_h_q <= cfg_data_i[CfgSideW-1:0];
        CfgTargetSide:   tgt_q   <= cfg_data_i[CfgTargetW-1:0];
        default: ;
      endcase
    end
  end

  // clamps
  always_comb begin
    if (src_w_q == '0) eff_w = SrcSideW'(1);
    else if (src_w_q > CfgSideW'(MaxSourceSide)) eff_w = SrcSideW'(MaxSourceSide);
    else eff_w = SrcSideW'(src_w_q);
    if (src_h_q == '0) eff_h = SrcSideW'(1);
    else if (src_h_q > CfgSideW'(MaxSourceSide)) eff_h = SrcSideW'(MaxSourceSide);
    else eff_h = SrcSideW'(src_h_q);
    if (tgt_q == '0) side = OutSideW'(1);
    else if (tgt_q > CfgTargetW'(MaxOutputSide)) side = OutSideW'(MaxOutputSide);
    else side = tgt_q[OutSideW-1:0];
  end

  assign fits   = (eff_w <= SrcSideW'(side)) && (eff_h <= SrcSideW'(side));
  assign w_long = (eff_w >= eff_h);

  assign col_p1     = {1'b0, SrcSideW'(src_col_q)} + (SrcSideW+1)'(1);
  assign row_p1     = {1'b0, SrcSideW'(src_row_q)} + (SrcSideW+1)'(1);
  assign out_col_p1 = out_col_q + OutSideW'(1);
  assign out_row_p1 = out_row_q + OutSideW'(1);
  assign row_case   = (out_col_p1 >= cw_q);
  assign src_last   = (SrcSideW'(src_col_q) == eff_w - SrcSideW'(1)) &&
                      (SrcSideW'(src_row_q) == eff_h - SrcSideW'(1));

  // multiplier operand select
  always_comb begin
    if (cmd_i.mul_begin) begin
      mul_a    = w_long ? eff_h : eff_w;
      mul_b    = side;
      mul_den  = w_long ? eff_w : eff_h;
      mul_dest = DEST_DIM;
    end else if (row_case) begin
      mul_a    = eff_h;
      mul_b    = out_row_p1;
      mul_den  = DivDenW'(ch_q);
      mul_dest = DEST_ROW;
    end else begin
      mul_a    = eff_w;
      mul_b    = out_col_p1;
      mul_den  = DivDenW'(cw_q);
      mul_dest = DEST_COL;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      pix_q <= pixel_in_i;
      sof_q <= start_of_image_i;
    end
    if (cmd_i.mul_begin || cmd_i.mul_step) begin
      prod_q <= DivNumW'(mul_a) * DivNumW'(mul_b);
      den_q  <= mul_den;
      dest_q <= mul_dest;
    end
  end

  nnfd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (prod_q),
    .den_i   (den_q),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // zero size forced to one
  assign quo_dim = (div_quo == '0) ? OutSideW'(1) : div_quo[OutSideW-1:0];

  always_comb begin
    src_col_d = src_col_q;
    src_row_d = src_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    nwc_d     = nwc_q;
    nwr_d     = nwr_q;
    cw_d      = cw_q;
    ch_d      = ch_q;
    long_w_d  = long_w_q;
    if (cmd_i.begin_img) begin
      src_col_d = '0;
      src_row_d = '0;
      out_col_d = '0;
      out_row_d = '0;
      nwc_d     = '0;
      nwr_d     = '0;
      long_w_d  = w_long;
      if (fits) begin
        cw_d = '0;
        ch_d = '0;
      end else begin
        cw_d = w_long ? side : '0;
        ch_d = w_long ? '0 : side;
      end
    end
    if (cmd_i.emit && !stat_o.stat_hit) begin
      if (row_case) begin
        out_col_d = '0;
        out_row_d = out_row_p1;
        nwc_d     = '0;
      end else begin
        out_col_d = out_col_p1;
      end
    end
    if (cmd_i.div_write) begin
      case (dest_q)
        DEST_DIM: begin
          if (long_w_q) ch_d = quo_dim;
          else cw_d = quo_dim;
        end
        DEST_COL: nwc_d = div_quo[SrcIdxW-1:0];
        DEST_ROW: nwr_d = div_quo[SrcIdxW-1:0];
        default: ;
      endcase
    end
    if (cmd_i.advance) begin
      if (col_p1 >= {1'b0, eff_w}) begin
        src_col_d = '0;
        if (row_p1 >= {1'b0, eff_h}) src_row_d = '0;
        else src_row_d = row_p1[SrcIdxW-1:0];
      end else begin
        src_col_d = col_p1[SrcIdxW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_col_q <= '0;
      src_row_q <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      nwc_q     <= '0;
      nwr_q     <= '0;
      cw_q      <= '0;
      ch_q      <= '0;
      long_w_q  <= 1'b0;
    end else begin
      src_col_q <= src_col_d;
      src_row_q <= src_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      nwc_q     <= nwc_d;
      nwr_q     <= nwr_d;
      cw_q      <= cw_d;
      ch_q      <= ch_d;
      long_w_q  <= long_w_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      if (stat_o.stat_hit) begin
        out_pix_q    <= '0;
        out_x_q      <= '0;
        out_y_q      <= '0;
        out_w_q      <= '0;
        out_h_q      <= '0;
        out_last_q   <= 1'b1;
        out_status_q <= 1'b1;
      end else begin
        out_pix_q    <= pix_q;
        out_x_q      <= out_col_q;
        out_y_q      <= out_row_q;
        out_w_q      <= cw_q;
        out_h_q      <= ch_q;
        out_last_q   <= (out_col_p1 == cw_q) && (out_row_p1 == ch_q);
        out_status_q <= 1'b0;
      end
    end
  end

  assign stat_o.begin_req = sof_q || (src_col_q == '0 && src_row_q == '0);
  assign stat_o.begin_div = !fits;
  assign stat_o.hit       = (out_row_q < ch_q) && (out_col_q < cw_q) &&
                            (src_row_q == nwr_q) && (src_col_q == nwc_q);
  assign stat_o.stat_hit  = (cw_q == '0) && src_last;
  assign stat_o.need_div  = row_case ? (out_row_p1 < ch_q) : 1'b1;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;
  assign stat_o.div_busy  = div_busy;
  assign stat_o.div_done  = div_done;

  assign out_valid_o  = out_valid_q;
  assign pixel_out_o  = out_pix_q;
  assign out_x_o      = out_x_q;
  assign out_y_o      = out_y_q;
  assign out_width_o  = out_w_q;
  assign out_height_o = out_h_q;
  assign last_pixel_o = out_last_q;
  assign status_o     = out_status_q;

`ifndef SYNTHESIS
  a_pos_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_status_q) |-> ((out_x_q < out_w_q) && (out_y_q < out_h_q)))
    else $error("scaled pixel lies outside the output frame");
`endif

endmodule

### hdl/nnfd_ctrl.sv
module nnfd_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  nnfd_pkg::nnfd_stat_t  stat_i,
  output nnfd_pkg::nnfd_cmd_t   cmd_o
);
  import nnfd_pkg::*;

  nnfd_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_CHECK;
        end
      end
      S_CHECK: begin
        state_d = S_EVAL;
        if (stat_i.begin_req) begin
          cmd_o.begin_img = 1'b1;
          if (stat_i.begin_div) begin
            cmd_o.mul_begin = 1'b1;
            state_d         = S_BGO;
          end
        end
      end
      S_BGO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_BWAIT;
      end
      S_BWAIT: begin
        if (stat_i.div_done) begin
          cmd_o.div_write = 1'b1;
          state_d         = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stat_i.hit || stat_i.stat_hit) begin
          if (stat_i.out_free) begin
            cmd_o.emit = 1'b1;
            if (stat_i.hit && stat_i.need_div) begin
              cmd_o.mul_step = 1'b1;
              state_d        = S_NGO;
            end else begin
              cmd_o.advance = 1'b1;
              state_d       = S_IDLE;
            end
          end
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_NGO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_NWAIT;
      end
      S_NWAIT: begin
        if (stat_i.div_done) begin
          cmd_o.div_write = 1'b1;
          cmd_o.advance   = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> stat_i.out_free)
    else $error("result written over an untaken beat");

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> !stat_i.div_busy)
    else $error("divider restarted while busy");

  a_accept_to_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_CHECK))
    else $error("accepted beat not followed by check");
`endif

endmodule

### hdl/nearest_neighbor_fit_downscaler.sv
// Flow: an accepted beat passes the check and evaluate states; its result beat is
//   registered at emit. A beat that opens an image that needs scaling first waits
//   for the image size divide; an emitted scaled pixel waits for the 21-step radix-2
//   divider. Emit stalls on an untaken output beat; no new beat is taken before idle.
// Reset: rst_ni asynchronous, active low; registers return to 320/320/240, all
//   position counters and the computed output size clear to zero.
module nearest_neighbor_fit_downscaler (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [nnfd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [nnfd_pkg::CfgDataW-1:0]  cfg_data_i,
  // source pixel beats
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [nnfd_pkg::PixW-1:0]      pixel_in_i,
  input  logic                           start_of_image_i,
  // result beats
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [nnfd_pkg::PixW-1:0]      pixel_out_o,
  output logic [nnfd_pkg::OutSideW-1:0]  out_x_o,
  output logic [nnfd_pkg::OutSideW-1:0]  out_y_o,
  output logic [nnfd_pkg::OutSideW-1:0]  out_width_o,
  output logic [nnfd_pkg::OutSideW-1:0]  out_height_o,
  output logic                           last_pixel_o,
  output logic                           status_o
);
  import nnfd_pkg::*;

  // Control: the FSM walks each input beat through check (image start),
  // optional output-size divide, evaluate/emit, and the divide that finds the
  // next wanted source column or row. A single multiplier feeds a single
  // serial divider; both are shared by the image-start and per-pixel paths.
  nnfd_cmd_t  cmd;
  nnfd_stat_t stat;

  nnfd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath: config registers, position counters, mult/divide, and the
  // output register that holds a finished beat while the next input is taken.
  nnfd_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .pixel_in_i       (pixel_in_i),
    .start_of_image_i (start_of_image_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .pixel_out_o      (pixel_out_o),
    .out_x_o          (out_x_o),
    .out_y_o          (out_y_o),
    .out_width_o      (out_width_o),
    .out_height_o     (out_height_o),
    .last_pixel_o     (last_pixel_o),
    .status_o         (status_o)
  );

endmodule
